// ===== sv/cbpf_pkg.sv =====
// Shared types and constants for the covalent bond pair finder.
// Used by every module of the block; depends on nothing else.
package cbpf_pkg;

   localparam int MAX_ATOMS   = 64;
   localparam int COORD_W     = 20;
   localparam int RADIUS_W    = 10;
   localparam int FACTOR_W    = 12;
   localparam int FACTOR_FRAC = 8;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd333;

   localparam int IDX_W     = $clog2(MAX_ATOMS);
   localparam int COUNT_W   = $clog2(MAX_ATOMS + 1);
   localparam int OUT_IDX_W = 6;

   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int D2_W   = SQ_W + 2;
   localparam int RSUM_W = RADIUS_W + 1;
   localparam int T_W    = RSUM_W + FACTOR_W;
   localparam int T2_W   = 2 * T_W;
   localparam int CMP_W  = (D2_W + 2 * FACTOR_FRAC > T2_W) ?
                           (D2_W + 2 * FACTOR_FRAC) : T2_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [RADIUS_W-1:0]       r;
   } atom_type;

   // One comparison slot traveling down the distance pipeline.
   typedef struct packed {
      logic             vld;
      logic             cmp;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] nidx;
      logic             fin;
   } tok_type;

   typedef struct packed {
      logic             vld;
      logic             hit;
      logic [IDX_W-1:0] eidx;
      logic [IDX_W-1:0] nidx;
      logic             fin;
   } res_type;

endpackage

// ===== sv/cbpf_cell.sv =====
// One cell of the circulating atom ring: holds a single stored atom.
// Depends on cbpf_pkg for the atom type.
module cbpf_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  logic               insert,
   input  cbpf_pkg::atom_type new_atom,
   input  cbpf_pkg::atom_type prev_atom,
   output cbpf_pkg::atom_type atom
);

   cbpf_pkg::atom_type atom_ff;
   cbpf_pkg::atom_type atom_in;

   always_comb begin
      atom_in = atom_ff;
      if (shift_en) begin
         atom_in = insert ? new_atom : prev_atom;
      end
   end

   always_ff @(posedge clock) begin
      atom_ff <= atom_in;
   end

   assign atom = atom_ff;

endmodule

// ===== sv/cbpf_dist.sv =====
// Four-stage pipelined bond test between the new atom and the ring head.
// Depends on cbpf_pkg for atom, token and result types.
module cbpf_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  cbpf_pkg::tok_type             tok,
   input  cbpf_pkg::atom_type            new_atom,
   input  cbpf_pkg::atom_type            head,
   input  logic [cbpf_pkg::FACTOR_W-1:0] factor,
   output cbpf_pkg::res_type             res
);

   function automatic logic [cbpf_pkg::DIFF_W-1:0] abs_diff(
      input logic [cbpf_pkg::COORD_W-1:0] a,
      input logic [cbpf_pkg::COORD_W-1:0] b
   );
      logic [cbpf_pkg::DIFF_W-1:0] d;
      d = {a[cbpf_pkg::COORD_W-1], a} - {b[cbpf_pkg::COORD_W-1], b};
      return d[cbpf_pkg::DIFF_W-1] ? (~d + 1'b1) : d;
   endfunction

   cbpf_pkg::tok_type s1_tok_ff, s1_tok_in, s2_tok_ff, s2_tok_in, s3_tok_ff, s3_tok_in;
   cbpf_pkg::res_type res_ff, res_in;

   logic [cbpf_pkg::DIFF_W-1:0] s1_adx_ff, s1_adx_in, s1_ady_ff, s1_ady_in;
   logic [cbpf_pkg::DIFF_W-1:0] s1_adz_ff, s1_adz_in;
   logic [cbpf_pkg::RSUM_W-1:0] s1_rsum_ff, s1_rsum_in;
   logic [cbpf_pkg::SQ_W-1:0]   s2_sqx_ff, s2_sqx_in, s2_sqy_ff, s2_sqy_in;
   logic [cbpf_pkg::SQ_W-1:0]   s2_sqz_ff, s2_sqz_in;
   logic [cbpf_pkg::T_W-1:0]    s2_t_ff, s2_t_in;
   logic [cbpf_pkg::D2_W-1:0]   s3_d2_ff, s3_d2_in;
   logic [cbpf_pkg::T2_W-1:0]   s3_t2_ff, s3_t2_in;
   logic [cbpf_pkg::CMP_W-1:0]  lhs, rhs;

   always_comb begin
      s1_tok_in  = s1_tok_ff;
      s2_tok_in  = s2_tok_ff;
      s3_tok_in  = s3_tok_ff;
      res_in     = res_ff;
      s1_adx_in  = s1_adx_ff;
      s1_ady_in  = s1_ady_ff;
      s1_adz_in  = s1_adz_ff;
      s1_rsum_in = s1_rsum_ff;
      s2_sqx_in  = s2_sqx_ff;
      s2_sqy_in  = s2_sqy_ff;
      s2_sqz_in  = s2_sqz_ff;
      s2_t_in    = s2_t_ff;
      s3_d2_in   = s3_d2_ff;
      s3_t2_in   = s3_t2_ff;

      // The bond holds when d2 * 2^16 < t^2; this also rules out a zero threshold.
      lhs = cbpf_pkg::CMP_W'({s3_d2_ff, {(2 * cbpf_pkg::FACTOR_FRAC){1'b0}}});
      rhs = cbpf_pkg::CMP_W'(s3_t2_ff);

      if (adv) begin
         s1_tok_in  = tok;
         s1_adx_in  = abs_diff(new_atom.x, head.x);
         s1_ady_in  = abs_diff(new_atom.y, head.y);
         s1_adz_in  = abs_diff(new_atom.z, head.z);
         s1_rsum_in = cbpf_pkg::RSUM_W'(new_atom.r) + cbpf_pkg::RSUM_W'(head.r);

         s2_tok_in = s1_tok_ff;
         s2_sqx_in = cbpf_pkg::SQ_W'(s1_adx_ff) * cbpf_pkg::SQ_W'(s1_adx_ff);
         s2_sqy_in = cbpf_pkg::SQ_W'(s1_ady_ff) * cbpf_pkg::SQ_W'(s1_ady_ff);
         s2_sqz_in = cbpf_pkg::SQ_W'(s1_adz_ff) * cbpf_pkg::SQ_W'(s1_adz_ff);
         s2_t_in   = cbpf_pkg::T_W'(s1_rsum_ff) * cbpf_pkg::T_W'(factor);

         s3_tok_in = s2_tok_ff;
         s3_d2_in  = cbpf_pkg::D2_W'(s2_sqx_ff) + cbpf_pkg::D2_W'(s2_sqy_ff)
                   + cbpf_pkg::D2_W'(s2_sqz_ff);
         s3_t2_in  = cbpf_pkg::T2_W'(s2_t_ff) * cbpf_pkg::T2_W'(s2_t_ff);

         res_in.vld  = s3_tok_ff.vld;
         res_in.hit  = s3_tok_ff.vld && s3_tok_ff.cmp && (lhs < rhs);
         res_in.eidx = s3_tok_ff.idx;
         res_in.nidx = s3_tok_ff.nidx;
         res_in.fin  = s3_tok_ff.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tok_ff <= '0;
         s2_tok_ff <= '0;
         s3_tok_ff <= '0;
         res_ff    <= '0;
      end else begin
         s1_tok_ff <= s1_tok_in;
         s2_tok_ff <= s2_tok_in;
         s3_tok_ff <= s3_tok_in;
         res_ff    <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_adx_ff  <= s1_adx_in;
      s1_ady_ff  <= s1_ady_in;
      s1_adz_ff  <= s1_adz_in;
      s1_rsum_ff <= s1_rsum_in;
      s2_sqx_ff  <= s2_sqx_in;
      s2_sqy_ff  <= s2_sqy_in;
      s2_sqz_ff  <= s2_sqz_in;
      s2_t_ff    <= s2_t_in;
      s3_d2_ff   <= s3_d2_in;
      s3_t2_ff   <= s3_t2_in;
   end

   assign res = res_ff;

endmodule

// ===== sv/cbpf_emit.sv =====
// Result stage: holds back one bonded pair so the final pair of an atom
// can be marked, and drives the output word register. Depends on cbpf_pkg.
module cbpf_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  cbpf_pkg::res_type              res,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [cbpf_pkg::OUT_IDX_W-1:0] rsp_earlier_index,
   output logic [cbpf_pkg::OUT_IDX_W-1:0] rsp_new_index,
   output logic                           rsp_last,
   output logic                           adv
);

   logic                       pend_vld_ff, pend_vld_in;
   logic [cbpf_pkg::IDX_W-1:0] pend_eidx_ff, pend_eidx_in, pend_nidx_ff, pend_nidx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cbpf_pkg::OUT_IDX_W-1:0] out_eidx_ff, out_eidx_in, out_nidx_ff, out_nidx_in;
   logic                       out_last_ff, out_last_in;

   always_comb begin
      // The whole scan freezes while a word sits stalled in the output register.
      adv          = !rsp_valid_ff || !rsp_stall;
      pend_vld_in  = pend_vld_ff;
      pend_eidx_in = pend_eidx_ff;
      pend_nidx_in = pend_nidx_ff;
      rsp_valid_in = rsp_valid_ff;
      out_eidx_in  = out_eidx_ff;
      out_nidx_in  = out_nidx_ff;
      out_last_in  = out_last_ff;

      if (adv) begin
         rsp_valid_in = 1'b0;
         out_eidx_in  = cbpf_pkg::OUT_IDX_W'(pend_eidx_ff);
         out_nidx_in  = cbpf_pkg::OUT_IDX_W'(pend_nidx_ff);
         if (res.vld && res.hit) begin
            rsp_valid_in = pend_vld_ff;
            out_last_in  = 1'b0;
            pend_vld_in  = 1'b1;
            pend_eidx_in = res.eidx;
            pend_nidx_in = res.nidx;
         end else if (res.vld && res.fin) begin
            rsp_valid_in = pend_vld_ff;
            out_last_in  = 1'b1;
            pend_vld_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_eidx_ff <= pend_eidx_in;
      pend_nidx_ff <= pend_nidx_in;
      out_eidx_ff  <= out_eidx_in;
      out_nidx_ff  <= out_nidx_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_earlier_index = out_eidx_ff;
   assign rsp_new_index     = out_nidx_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ===== sv/covalent_bond_pair_finder_unit.sv =====
// Top level of the covalent bond pair finder: scan control, the atom ring,
// the bond test pipeline and the result stage. Depends on cbpf_pkg,
// cbpf_cell, cbpf_dist and cbpf_emit.
//
// Usage: one atom word enters on the req_ channel (valid/stall). Stored atoms
// circulate in a ring of 64 cells; the ring head feeds one pipelined bond
// test per cycle while no word is stalled at the output. An atom is accepted
// and then takes one full turn of the ring, during which req_stall stays high.
// The new atom is put into the ring as its slot passes the tail. Every bonded
// pair leaves on the rsp_ channel as one word, in increasing order of the
// earlier index, with rsp_last set on the final pair of that atom. Each pair
// waits for the next bonded pair of the same atom, and the final pair waits
// until the turn ends. An atom past the 64-atom capacity is accepted but not
// stored and gives no word. While a word waits in the output register under
// rsp_stall, the ring and the pipeline freeze. bond_factor is written on the
// csr_ channel, always ready; it is to be written only while idle, which the
// block itself does not enforce. Reset clears the atom count, the pipeline and
// the output, and sets bond_factor to 333; stored atom values are not cleared.
module covalent_bond_pair_finder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_first_atom,
   input  logic signed [cbpf_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [cbpf_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [cbpf_pkg::COORD_W-1:0]   req_pos_z,
   input  logic [cbpf_pkg::RADIUS_W-1:0]         req_radius,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cbpf_pkg::OUT_IDX_W-1:0]        rsp_earlier_index,
   output logic [cbpf_pkg::OUT_IDX_W-1:0]        rsp_new_index,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cbpf_pkg::FACTOR_W-1:0]         csr_bond_factor
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_SCAN = 1'b1;

   logic [0:0]                   state_ff, state_in;
   logic [cbpf_pkg::IDX_W-1:0]   step_ff, step_in;
   logic [cbpf_pkg::COUNT_W-1:0] count_ff, count_in, scan_count_ff, scan_count_in;
   logic [cbpf_pkg::COUNT_W-1:0] base_count;
   logic [cbpf_pkg::FACTOR_W-1:0] factor_ff, factor_in;
   cbpf_pkg::atom_type           new_atom_ff, new_atom_in;
   cbpf_pkg::tok_type            tok;
   cbpf_pkg::res_type            res;
   cbpf_pkg::atom_type           ring [cbpf_pkg::MAX_ATOMS];
   logic                         accept, adv, shift_en, insert, last_step;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      scan_count_in = scan_count_ff;
      new_atom_in   = new_atom_ff;
      factor_in     = (csr_valid && csr_ready) ? csr_bond_factor : factor_ff;
      base_count    = req_first_atom ? '0 : count_ff;
      last_step     = (step_ff == cbpf_pkg::IDX_W'(cbpf_pkg::MAX_ATOMS - 1));
      tok           = '0;
      shift_en      = 1'b0;
      insert        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = base_count;
               if (base_count < cbpf_pkg::COUNT_W'(cbpf_pkg::MAX_ATOMS)) begin
                  new_atom_in.x = req_pos_x;
                  new_atom_in.y = req_pos_y;
                  new_atom_in.z = req_pos_z;
                  new_atom_in.r = req_radius;
                  scan_count_in = base_count;
                  step_in       = '0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (adv) begin
               // Before step k shifts the head holds stored atom k.
               shift_en = 1'b1;
               insert   = (cbpf_pkg::COUNT_W'(step_ff) == scan_count_ff);
               tok.vld  = 1'b1;
               tok.cmp  = (cbpf_pkg::COUNT_W'(step_ff) < scan_count_ff);
               tok.idx  = step_ff;
               tok.nidx = scan_count_ff[cbpf_pkg::IDX_W-1:0];
               tok.fin  = last_step;
               step_in  = step_ff + 1'b1;
               if (last_step) begin
                  step_in  = '0;
                  count_in = scan_count_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         count_ff      <= '0;
         scan_count_ff <= '0;
         factor_ff     <= cbpf_pkg::FACTOR_RESET;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         count_ff      <= count_in;
         scan_count_ff <= scan_count_in;
         factor_ff     <= factor_in;
      end
   end

   always_ff @(posedge clock) begin
      new_atom_ff <= new_atom_in;
   end

   for (genvar g = 0; g < cbpf_pkg::MAX_ATOMS; g++) begin : g_ring
      cbpf_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .insert    ((g == cbpf_pkg::MAX_ATOMS - 1) ? insert : 1'b0),
         .new_atom  (new_atom_ff),
         .prev_atom (ring[(g + 1) % cbpf_pkg::MAX_ATOMS]),
         .atom      (ring[g])
      );
   end

   cbpf_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .tok      (tok),
      .new_atom (new_atom_ff),
      .head     (ring[0]),
      .factor   (factor_ff),
      .res      (res)
   );

   cbpf_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .res               (res),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_new_index     (rsp_new_index),
      .rsp_last          (rsp_last),
      .adv               (adv)
   );

endmodule

// ===== verif/cbpf_bond_checker.sv =====
// Bond pair checker: watches the atom, pair and bond_factor channels of the
// pair finder, predicts every bonded pair and compares it with the pair words.
// Depends on cbpf_pkg for widths, the atom type and the bond_factor reset value.
`timescale 1ns / 100ps

module cbpf_bond_checker
   import cbpf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_first_atom,
   input  logic signed [COORD_W-1:0]  req_pos_x,
   input  logic signed [COORD_W-1:0]  req_pos_y,
   input  logic signed [COORD_W-1:0]  req_pos_z,
   input  logic [RADIUS_W-1:0]        req_radius,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [OUT_IDX_W-1:0]       rsp_earlier_index,
   input  logic [OUT_IDX_W-1:0]       rsp_new_index,
   input  logic                       rsp_last,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [FACTOR_W-1:0]        csr_bond_factor,
   output int                         error_count,
   output int                         pending_pairs
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [OUT_IDX_W-1:0] earlier;
      logic [OUT_IDX_W-1:0] newer;
      logic                 is_last;
   } bond_pair_type;

   atom_type            atoms [MAX_ATOMS];
   int                  stored_count;
   logic [FACTOR_W-1:0] factor;
   bond_pair_type       bond_q [$];

   function automatic logic [63:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                           input logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return 64'(d * d);
   endfunction

   // Compares the new atom with every stored one and queues the bonded pairs,
   // then stores it. Past capacity the atom is dropped without any pair.
   task automatic store_atom(input atom_type a, input logic first);
      logic [63:0]          d2;
      logic [63:0]          t;
      logic [63:0]          t2;
      logic [MAX_ATOMS-1:0] hits;
      int                   top_hit;
      bond_pair_type        pair;
      if (first)
         stored_count = 0;
      if (stored_count < MAX_ATOMS) begin
         hits = '0;
         top_hit = -1;
         for (int i = 0; i < stored_count; i++) begin
            d2 = sq_diff(a.x, atoms[i].x) + sq_diff(a.y, atoms[i].y)
               + sq_diff(a.z, atoms[i].z);
            t = (64'(a.r) + 64'(atoms[i].r)) * 64'(factor);
            t2 = t * t;
            // Strictly inside the cutoff, compared without any rounding.
            if (t2 != 0 && d2 <= ((t2 - 64'd1) >> (2 * FACTOR_FRAC))) begin
               hits[i] = 1'b1;
               top_hit = i;
            end
         end
         for (int i = 0; i < stored_count; i++) begin
            if (hits[i]) begin
               pair.earlier = OUT_IDX_W'(i);
               pair.newer = OUT_IDX_W'(stored_count);
               pair.is_last = (i == top_hit);
               bond_q.push_back(pair);
            end
         end
         atoms[stored_count] = a;
         stored_count++;
      end
   endtask

   task automatic check_pair_word();
      bond_pair_type want;
      if (bond_q.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: unexpected pair word: earlier %0d new %0d last %0b",
                     $time, rsp_earlier_index, rsp_new_index, rsp_last);
      end else begin
         want = bond_q.pop_front();
         if (rsp_earlier_index !== want.earlier || rsp_new_index !== want.newer ||
             rsp_last !== want.is_last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: pair mismatch: expected %0d/%0d last %0b, got %0d/%0d last %0b",
                        $time, want.earlier, want.newer, want.is_last,
                        rsp_earlier_index, rsp_new_index, rsp_last);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      atom_type incoming;
      if (reset) begin
         factor = FACTOR_RESET;
         stored_count = 0;
         bond_q.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            factor = csr_bond_factor;
         // A word leaving now belongs to an earlier atom, so pop before pushing.
         if (rsp_valid && !rsp_stall)
            check_pair_word();
         if (req_valid && !req_stall) begin
            incoming.x = req_pos_x;
            incoming.y = req_pos_y;
            incoming.z = req_pos_z;
            incoming.r = req_radius;
            store_atom(incoming, req_first_atom);
         end
      end
      pending_pairs = bond_q.size();
   end

endmodule

// ===== verif/tb_covalent_bond_pair_finder_unit.sv =====
// Testbench top for the covalent bond pair finder: clock, reset, atom and
// bond_factor stimulus, output stalls and the verdict. Depends on cbpf_pkg,
// cbpf_bond_checker and the covalent_bond_pair_finder_unit RTL.
`timescale 1ns / 100ps

module tb_covalent_bond_pair_finder_unit;
   import cbpf_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 80;
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [RADIUS_W-1:0] RADIUS_MAX  = '1;
   localparam logic [FACTOR_W-1:0] FACTOR_ZERO = '0;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE  = 12'd256;
   localparam logic [FACTOR_W-1:0] FACTOR_MAX  = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_first_atom;
   logic signed [COORD_W-1:0] req_pos_x;
   logic signed [COORD_W-1:0] req_pos_y;
   logic signed [COORD_W-1:0] req_pos_z;
   logic [RADIUS_W-1:0]       req_radius;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [OUT_IDX_W-1:0]      rsp_earlier_index;
   logic [OUT_IDX_W-1:0]      rsp_new_index;
   logic                      rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [FACTOR_W-1:0]       csr_bond_factor;

   int error_count;
   int pending_pairs;
   int quiet_cycles;
   bit timed_out;
   bit no_gaps;
   bit stall_off;

   covalent_bond_pair_finder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_first_atom    (req_first_atom),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_radius        (req_radius),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_new_index     (rsp_new_index),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_bond_factor   (csr_bond_factor)
   );

   cbpf_bond_checker bond_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_first_atom    (req_first_atom),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_radius        (req_radius),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_new_index     (rsp_new_index),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_bond_factor   (csr_bond_factor),
      .error_count       (error_count),
      .pending_pairs     (pending_pairs)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (no_gaps)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int jitter(input int spread);
      return int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // All tasks below but run_stimulus, which ends on a rising edge, are entered
   // and left on a falling edge. After send_atom returns, valid is still high, so
   // the caller either sends the next atom or drops valid in that same step.
   task automatic send_atom(input logic first, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z,
                            input logic [RADIUS_W-1:0] r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_atom <= first;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_radius <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_req();
      req_valid <= 1'b0;
   endtask

   // Waits for every pair word, then for the turn of an atom with no bonds.
   task automatic settle_block();
      idle_req();
      wait (pending_pairs == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_factor(input logic [FACTOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_bond_factor <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One structure: a flagged first atom and the rest, all scattered around one random centre.
   task automatic send_structure(input int count, input int spread,
                                 input int r_lo, input int r_hi);
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      cx = COORD_W'($urandom);
      cy = COORD_W'($urandom);
      cz = COORD_W'($urandom);
      for (int i = 0; i < count; i++)
         send_atom(i == 0, COORD_W'(cx + jitter(spread)), COORD_W'(cy + jitter(spread)),
                   COORD_W'(cz + jitter(spread)), RADIUS_W'($urandom_range(r_lo, r_hi)));
   endtask

   task automatic send_noise();
      send_atom($urandom_range(0, 7) == 0, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), RADIUS_W'($urandom));
   endtask

   task automatic run_phase(input int atom_total, input logic [FACTOR_W-1:0] value);
      int sent;
      int roll;
      int count;
      settle_block();
      write_factor(value);
      sent = 0;
      while (sent < atom_total) begin
         roll = $urandom_range(0, 19);
         if (roll < 14) begin
            count = $urandom_range(2, 12);
            send_structure(count, 64 << (2 * $urandom_range(0, 3)), 0, RADIUS_MAX);
            sent += count;
         end else if (roll < 19) begin
            send_noise();
            sent++;
         end else begin
            // Hold the next word back until the block has drained.
            idle_req();
            wait (pending_pairs == 0);
            @(negedge clock);
         end
      end
   endtask

   task automatic run_stimulus();
      // Bond_factor still at its reset value; the store starts empty.
      send_atom(1'b0, 0, 0, 0, 0);
      send_atom(1'b0, 0, 0, 0, 0);
      send_atom(1'b0, 0, 0, 0, RADIUS_MAX);
      send_atom(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
      send_atom(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX);
      send_atom(1'b1, COORD_MIN, 0, COORD_MAX, 0);
      send_atom(1'b0, COORD_W'(COORD_MIN + 1), 1, COORD_W'(COORD_MAX - 1), 1);

      // Unit factor: a distance equal to the summed radii must not bond.
      settle_block();
      write_factor(FACTOR_ONE);
      send_atom(1'b1, 0, 0, 0, 100);
      send_atom(1'b0, 200, 0, 0, 100);
      send_atom(1'b0, 0, 199, 0, 100);
      send_atom(1'b0, 0, 0, -20'sd199, 100);

      settle_block();
      write_factor(FACTOR_MAX);
      send_atom(1'b1, COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX);
      send_atom(1'b0, COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX);
      send_atom(1'b0, COORD_W'(COORD_MAX - 1000), COORD_W'(COORD_MIN + 1000), COORD_MAX, 0);

      // A zero factor never bonds, not even two atoms at the same spot.
      settle_block();
      write_factor(FACTOR_ZERO);
      send_atom(1'b1, 5, 5, 5, RADIUS_MAX);
      send_atom(1'b0, 5, 5, 5, RADIUS_MAX);

      run_phase(60, FACTOR_RESET);
      run_phase(35, FACTOR_MAX);
      run_phase(20, FACTOR_ZERO);
      run_phase(40, FACTOR_W'($urandom_range(1, 4094)));

      // Full speed on both sides, then a dense cluster that overruns capacity.
      no_gaps = 1'b1;
      stall_off = 1'b1;
      run_phase(25, FACTOR_ONE);
      send_structure(MAX_ATOMS + 2, 40, 200, 400);
      no_gaps = 1'b0;
      stall_off = 1'b0;
      run_phase(25, FACTOR_W'($urandom_range(1, 4094)));

      idle_req();
      wait (pending_pairs == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_backpressure
      int  hold;
      int  roll;
      bit  stalled;
      hold = 0;
      stalled = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_off) begin
            if (stalled)
               rsp_stall <= 1'b0;
            stalled = 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else if (stalled) begin
            stalled = 1'b0;
            rsp_stall <= 1'b0;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 6);
         end else begin
            stalled = 1'b1;
            rsp_stall <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 80)
               hold = $urandom_range(0, 2);
            else if (roll < 95)
               hold = $urandom_range(3, 11);
            else
               hold = $urandom_range(19, 59);
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_atom = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_radius = '0;
      csr_valid = 1'b0;
      csr_bond_factor = '0;
      timed_out = 1'b0;
      no_gaps = 1'b0;
      stall_off = 1'b0;
      quiet_cycles = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      fork
         run_stimulus();
         begin : watchdog
            while (quiet_cycles < WATCHDOG_LIMIT) begin
               @(posedge clock);
               if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready))
                  quiet_cycles = 0;
               else
                  quiet_cycles++;
            end
            timed_out = 1'b1;
         end
      join_any
      if (!timed_out && error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== covalent_bond_pair_finder_unit.f =====
sv/cbpf_pkg.sv
sv/cbpf_cell.sv
sv/cbpf_dist.sv
sv/cbpf_emit.sv
sv/covalent_bond_pair_finder_unit.sv
verif/cbpf_bond_checker.sv
verif/tb_covalent_bond_pair_finder_unit.sv
